FILE: sv/fba_pkg.sv
// fba_pkg: shared types and codes for the fit block allocator
// item structs, controller command/status structs, kind/mode/register codes
// no dependencies
`default_nettype none

package fba_pkg;

    localparam int IDX_FIELD_W  = 6;
    localparam int SIZE_FIELD_W = 16;
    localparam int TOTAL_W      = 22;
    localparam int COUNT_W      = 7;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // item kinds
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_ALLOC  = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FIT_MODE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT = 2'd1;

    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 7'd64;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_NEXT  = 2'd1,
        FIT_BEST  = 2'd2,
        FIT_WORST = 2'd3
    } fit_mode_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic [IDX_FIELD_W-1:0]  load_index;
        logic [SIZE_FIELD_W-1:0] size_value;
    } req_item_t;

    typedef struct packed {
        logic                    granted;
        logic [IDX_FIELD_W-1:0]  chosen_block;
        logic [SIZE_FIELD_W-1:0] leftover;
        logic [TOTAL_W-1:0]      internal_total;
        logic [TOTAL_W-1:0]      external_total;
    } rsp_item_t;

    typedef struct packed {
        logic capture;
        logic scan_step;
        logic commit;
        logic emit;
    } fba_cmd_t;

    typedef struct packed {
        logic scan_kind;
        logic scan_last;
        logic out_busy;
    } fba_status_t;

endpackage

`default_nettype wire

FILE: sv/fba_ctrl.sv
// fba_ctrl: sequencing state machine for the fit block allocator
// drives datapath commands from its status; uses fba_pkg
`default_nettype none

module fba_ctrl
    import fba_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire fba_status_t status,
    output fba_cmd_t         cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_COMMIT = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = status.scan_kind ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            // last entry read is evaluated here
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/fba_dpath.sv
// fba_dpath: block size memory, used marks, scan pointer, fit compare and totals
// holds the result register; uses fba_pkg, driven by fba_ctrl commands
`default_nettype none

module fba_dpath
    import fba_pkg::*;
#(
    parameter int MAX_BLOCKS = 64,
    parameter int SIZE_BITS  = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire req_item_t                     req_item,
    input  wire fit_mode_t                     fit_mode,
    input  wire logic [$clog2(MAX_BLOCKS):0]   active_n,
    input  wire fba_cmd_t                      cmd,
    output fba_status_t                        status,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output rsp_item_t                          rsp_item
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = IDX_W + 1;
    localparam int SUM_W = ((SIZE_BITS > TOTAL_W) ? SIZE_BITS : TOTAL_W) + 1;

    logic [SIZE_BITS-1:0] size_mem [MAX_BLOCKS];

    logic [MAX_BLOCKS-1:0] used_reg;
    logic [IDX_W-1:0]      next_ptr_reg;
    logic [TOTAL_W-1:0]    sum_reg;
    logic [TOTAL_W-1:0]    sum_next;
    logic                  eval_reg;
    logic                  found_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  rsp_valid_reg;

    logic [1:0]            kind_reg;
    logic [SIZE_BITS-1:0]  req_reg;
    logic [IDX_W-1:0]      addr_reg;
    logic [SIZE_BITS-1:0]  rd_size_reg;
    logic                  rd_used_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic [IDX_W-1:0]      pick_reg;
    logic [SIZE_BITS-1:0]  pick_size_reg;
    logic [TOTAL_W-1:0]    ext_reg;
    logic [TOTAL_W-1:0]    ext_next;
    logic [SIZE_BITS-1:0]  left_reg;
    rsp_item_t             rsp_reg;

    logic                  load_hit;
    logic [IDX_W-1:0]      load_idx;
    logic [IDX_W-1:0]      start_addr;
    logic [CNT_W-1:0]      last_pos;
    logic                  fits;
    logic                  better;
    logic                  take;
    logic                  granted;
    logic [SIZE_BITS-1:0]  left_full;
    logic [SUM_W-1:0]      ext_wide;
    logic [SUM_W-1:0]      sum_wide;

    assign load_hit = cmd.capture && (req_item.kind == KIND_LOAD)
                      && (32'(req_item.load_index) < MAX_BLOCKS);
    assign load_idx = IDX_W'(req_item.load_index);
    assign last_pos = active_n - CNT_W'(1);

    // next fit resumes at the last granted block when it is still in range
    assign start_addr = ((fit_mode == FIT_NEXT) && (req_item.kind == KIND_ALLOC)
                         && ({1'b0, next_ptr_reg} < active_n)) ? next_ptr_reg : '0;

    assign fits   = !rd_used_reg && (rd_size_reg >= req_reg);
    assign better = !found_reg
                    || ((fit_mode == FIT_BEST)  && (rd_size_reg < pick_size_reg))
                    || ((fit_mode == FIT_WORST) && (rd_size_reg > pick_size_reg));
    assign take   = eval_reg && (kind_reg == KIND_ALLOC) && fits && better;

    assign granted   = (kind_reg == KIND_ALLOC) && found_reg;
    assign left_full = pick_size_reg - req_reg;

    assign ext_wide = SUM_W'(ext_reg) + SUM_W'(rd_size_reg);
    assign ext_next = (ext_wide > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : ext_wide[TOTAL_W-1:0];
    assign sum_wide = SUM_W'(sum_reg) + SUM_W'(left_full);
    assign sum_next = (sum_wide > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];

    assign status.scan_kind = (req_item.kind == KIND_ALLOC) || (req_item.kind == KIND_REPORT);
    assign status.scan_last = (cnt_reg == last_pos);
    assign status.out_busy  = rsp_valid_reg && rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

    // single port memory, registered read
    always_ff @(posedge clk)
    begin
        if (load_hit)
        begin
            size_mem[load_idx] <= SIZE_BITS'(req_item.size_value);
        end
        rd_size_reg <= size_mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            next_ptr_reg  <= '0;
            sum_reg       <= '0;
            eval_reg      <= 1'b0;
            found_reg     <= 1'b0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            eval_reg <= cmd.scan_step;
            if (load_hit)
            begin
                used_reg[load_idx] <= 1'b0;
            end
            if (cmd.capture)
            begin
                found_reg <= 1'b0;
                cnt_reg   <= '0;
            end
            else if (cmd.scan_step)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (take)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.commit && granted)
            begin
                used_reg[pick_reg] <= 1'b1;
                next_ptr_reg       <= pick_reg;
                sum_reg            <= sum_next;
            end
            if (cmd.emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_used_reg <= used_reg[addr_reg];
        rd_idx_reg  <= addr_reg;
        if (cmd.capture)
        begin
            kind_reg <= req_item.kind;
            req_reg  <= SIZE_BITS'(req_item.size_value);
            addr_reg <= start_addr;
            ext_reg  <= '0;
        end
        else if (cmd.scan_step)
        begin
            addr_reg <= ({1'b0, addr_reg} == last_pos) ? '0 : addr_reg + IDX_W'(1);
        end
        if (take)
        begin
            pick_reg      <= rd_idx_reg;
            pick_size_reg <= rd_size_reg;
        end
        if (eval_reg && (kind_reg == KIND_REPORT) && !rd_used_reg)
        begin
            ext_reg <= ext_next;
        end
        if (cmd.commit)
        begin
            left_reg <= left_full;
        end
        if (cmd.emit)
        begin
            rsp_reg.granted        <= granted;
            rsp_reg.chosen_block   <= granted ? IDX_FIELD_W'(pick_reg) : '0;
            rsp_reg.leftover       <= granted ? SIZE_FIELD_W'(left_reg) : '0;
            rsp_reg.internal_total <= sum_reg;
            rsp_reg.external_total <= (kind_reg == KIND_REPORT) ? ext_reg : '0;
        end
    end

`ifndef SYNTH
    a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && granted |-> ({1'b0, pick_reg} < active_n))
        else $error("granted block outside active range");

    a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(rsp_valid_reg && rsp_stall))
        else $error("result overwritten while stalled");

    a_sum_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (sum_reg >= $past(sum_reg)))
        else $error("internal total decreased");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> (cnt_reg < active_n))
        else $error("scan ran past block count");
`endif

endmodule

`default_nettype wire

FILE: sv/fit_block_allocator_core.sv
// Fit block allocator: a load item (kind 0) writes one block size and frees that block;
// an allocate item (kind 1) picks a free block of at least the request size by first,
// next, best or worst fit, marks it used and adds its leftover to the internal total;
// a report item (kind 2) returns the sum of free block sizes. Every item gives one
// result. Allocate and report items scan the size memory one entry per cycle, since
// it has one read port; load and other items skip the scan. A new item is accepted
// while a result waits on rsp_stall.
// No clearing pass follows reset; block sizes must be loaded before they are used.
//
// top level: configuration registers and block count clamp; uses fba_pkg,
// fba_ctrl and fba_dpath
`default_nettype none

module fit_block_allocator_core
    import fba_pkg::*;
#(
    parameter int MAX_BLOCKS = 64,
    parameter int SIZE_BITS  = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_stall,
    input  wire req_item_t              req_item,
    output logic                        rsp_valid,
    input  wire logic                   rsp_stall,
    output rsp_item_t                   rsp_item,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [COUNT_W-1:0]     cfg_data
);

    localparam int CNT_W = $clog2(MAX_BLOCKS) + 1;

    fit_mode_t          fit_mode_reg;
    logic [COUNT_W-1:0] block_count_reg;
    logic [CNT_W-1:0]   active_n;
    fba_cmd_t           cmd;
    fba_status_t        status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg    <= FIT_FIRST;
            block_count_reg <= BLOCK_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FIT_MODE:    fit_mode_reg    <= fit_mode_t'(cfg_data[1:0]);
                REG_BLOCK_COUNT: block_count_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // zero acts as one, anything past the table acts as the table size
    always_comb
    begin
        if (block_count_reg == '0)
        begin
            active_n = CNT_W'(1);
        end
        else if (32'(block_count_reg) > MAX_BLOCKS)
        begin
            active_n = CNT_W'(MAX_BLOCKS);
        end
        else
        begin
            active_n = CNT_W'(block_count_reg);
        end
    end

    fba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    fba_dpath #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_item  (req_item),
        .fit_mode  (fit_mode_reg),
        .active_n  (active_n),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

endmodule

`default_nettype wire

FILE: tb/tb.sv
// tb: self-checking testbench for fit_block_allocator_core
// a small scoreboard class predicts every response; plain tasks drive items and registers
// depends on fba_pkg and the allocator rtl
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fba_pkg::*;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int NUM_BLOCKS   = 64;
    localparam int SCAN_LATENCY = 72;
    localparam int PHASE_ITEMS  = 130;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 600;
    localparam int QUIET_LIMIT  = 5000;

    class alloc_scoreboard;
        logic [SIZE_FIELD_W-1:0] block_size [NUM_BLOCKS];
        bit                      block_used [NUM_BLOCKS];
        int unsigned             next_blk;
        int unsigned             frag_sum;
        fit_mode_t               mode;
        logic [COUNT_W-1:0]      count_reg;
        rsp_item_t               expected_q [$];
        int unsigned             mismatches;

        function new();
            foreach (block_size[i])
            begin
                block_size[i] = '0;
                block_used[i] = 1'b0;
            end
            next_blk   = 0;
            frag_sum   = 0;
            mode       = FIT_FIRST;
            count_reg  = BLOCK_COUNT_RESET;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [COUNT_W-1:0] data);
            if (idx == REG_FIT_MODE)
                mode = fit_mode_t'(data[1:0]);
            else if (idx == REG_BLOCK_COUNT)
                count_reg = data;
        endfunction

        function int live_blocks();
            if (count_reg == 0)
                return 1;
            if (count_reg > NUM_BLOCKS)
                return NUM_BLOCKS;
            return int'(count_reg);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // returns the chosen block, -1 when nothing fits
        function int pick_block(logic [SIZE_FIELD_W-1:0] req);
            int n;
            int start;
            int i;
            int k;
            int best;
            n    = live_blocks();
            best = -1;
            if (mode == FIT_NEXT)
            begin
                start = (next_blk < n) ? next_blk : 0;
                for (k = 0; k < n; k++)
                begin
                    i = (start + k) % n;
                    if (!block_used[i] && block_size[i] >= req)
                        return i;
                end
                return -1;
            end
            for (k = 0; k < n; k++)
            begin
                if (block_used[k] || block_size[k] < req)
                    continue;
                if (best < 0)
                begin
                    best = k;
                    if (mode == FIT_FIRST)
                        return best;
                end
                else if (mode == FIT_BEST && block_size[k] < block_size[best])
                    best = k;
                else if (mode == FIT_WORST && block_size[k] > block_size[best])
                    best = k;
            end
            return best;
        endfunction

        function void note_request(req_item_t item);
            rsp_item_t   exp;
            int          p;
            int          k;
            int unsigned ext;
            exp = '0;
            ext = 0;
            case (item.kind)
                KIND_LOAD:
                begin
                    block_size[item.load_index] = item.size_value;
                    block_used[item.load_index] = 1'b0;
                end
                KIND_ALLOC:
                begin
                    p = pick_block(item.size_value);
                    if (p >= 0)
                    begin
                        exp.granted      = 1'b1;
                        exp.chosen_block = IDX_FIELD_W'(p);
                        exp.leftover     = block_size[p] - item.size_value;
                        block_used[p]    = 1'b1;
                        next_blk         = p;
                        frag_sum         = frag_sum + exp.leftover;
                        if (frag_sum > TOTAL_MAX)
                            frag_sum = TOTAL_MAX;
                    end
                end
                KIND_REPORT:
                begin
                    for (k = 0; k < live_blocks(); k++)
                    begin
                        if (!block_used[k])
                            ext = ext + block_size[k];
                        if (ext > TOTAL_MAX)
                            ext = TOTAL_MAX;
                    end
                    exp.external_total = TOTAL_W'(ext);
                end
                default:
                begin
                end
            endcase
            exp.internal_total = TOTAL_W'(frag_sum);
            expected_q.push_back(exp);
        endfunction

        function void check_response(rsp_item_t got);
            rsp_item_t exp;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response g=%0d blk=%0d left=%0d int=%0d ext=%0d",
                             got.granted, got.chosen_block, got.leftover,
                             got.internal_total, got.external_total);
                return;
            end
            exp = expected_q.pop_front();
            if (got.granted !== exp.granted || got.chosen_block !== exp.chosen_block
                || got.leftover !== exp.leftover || got.internal_total !== exp.internal_total
                || got.external_total !== exp.external_total)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch exp g=%0d blk=%0d left=%0d int=%0d ext=%0d",
                             exp.granted, exp.chosen_block, exp.leftover,
                             exp.internal_total, exp.external_total);
                    $display("         got g=%0d blk=%0d left=%0d int=%0d ext=%0d",
                             got.granted, got.chosen_block, got.leftover,
                             got.internal_total, got.external_total);
                end
            end
        endfunction
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    req_item_t              req_item  = '0;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    rsp_item_t              rsp_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [COUNT_W-1:0]     cfg_data  = '0;

    alloc_scoreboard sb = new();

    bit          blk_written [NUM_BLOCKS];
    int unsigned rsp_count   = 0;
    int unsigned hold_left   = 0;
    bit          hold_done   = 1'b0;
    int unsigned quiet       = 0;
    logic        calm;

    // no random idling on either side in this window
    assign calm = (rsp_count >= 700 && rsp_count < 1000);

    fit_block_allocator_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // response side: check, then pick the next stall value
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            sb.check_response(rsp_item);
            rsp_count <= rsp_count + 1;
        end
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (!hold_done && rsp_count == HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= !calm && ($urandom_range(99) < 9);
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic req_item_t make_item(logic [1:0] k, int idx, int sz);
        req_item_t it;
        it.kind       = k;
        it.load_index = IDX_FIELD_W'(idx);
        it.size_value = SIZE_FIELD_W'(sz);
        return it;
    endfunction

    function automatic req_item_t random_item();
        req_item_t it;
        int        n;
        int        roll;
        int        j;
        n             = sb.live_blocks();
        roll          = $urandom_range(99);
        it.load_index = IDX_FIELD_W'($urandom_range(63));
        it.size_value = SIZE_FIELD_W'(($urandom_range(99) < 5) ? $urandom_range(65535)
                                                               : $urandom_range(1023));
        if (roll < 40)
        begin
            it.kind = KIND_LOAD;
            if ($urandom_range(4) != 0)
                it.load_index = IDX_FIELD_W'($urandom_range(n - 1));
        end
        else if (roll < 85)
            it.kind = KIND_ALLOC;
        else if (roll < 97)
            it.kind = KIND_REPORT;
        else
            it.kind = KIND_SPARE;
        // a scan must never touch a block that was never loaded
        if (it.kind == KIND_ALLOC || it.kind == KIND_REPORT)
        begin
            for (j = n - 1; j >= 0; j--)
            begin
                if (!blk_written[j])
                begin
                    it.kind       = KIND_LOAD;
                    it.load_index = IDX_FIELD_W'(j);
                end
            end
        end
        return it;
    endfunction

    task automatic send_item(input req_item_t item);
        while (!calm && $urandom_range(99) < 9)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (item.kind == KIND_LOAD)
            blk_written[item.load_index] = 1'b1;
        sb.note_request(item);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [COUNT_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    task automatic set_phase(input fit_mode_t m, input logic [COUNT_W-1:0] cnt);
        logic [4:0] junk;
        junk = 5'($urandom_range(31));
        write_reg(REG_FIT_MODE, {junk, m});
        write_reg(REG_BLOCK_COUNT, cnt);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SCAN_LATENCY)
            @(posedge clk);
    endtask

    fit_mode_t          phase_mode  [12] = '{FIT_FIRST, FIT_NEXT, FIT_NEXT, FIT_BEST,
                                             FIT_WORST, FIT_BEST, FIT_WORST, FIT_FIRST,
                                             FIT_NEXT, FIT_BEST, FIT_WORST, FIT_FIRST};
    logic [COUNT_W-1:0] phase_count [12] = '{7'd64, 7'd64, 7'd3, 7'd16, 7'd64, 7'd0,
                                             7'd100, 7'd127, 7'd33, 7'd64, 7'd1, 7'd64};

    initial
    begin
        int p;
        int r;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;

        // four small blocks with extreme sizes, first fit
        set_phase(FIT_FIRST, 7'd4);
        write_reg(REG_SPARE_A, 7'h7f);
        write_reg(REG_SPARE_B, 7'h55);
        send_item(make_item(KIND_LOAD, 0, 100));
        send_item(make_item(KIND_LOAD, 1, 65535));
        send_item(make_item(KIND_LOAD, 2, 0));
        send_item(make_item(KIND_LOAD, 3, 50));
        send_item(make_item(KIND_REPORT, 63, 65535));
        send_item(make_item(KIND_ALLOC, 0, 0));
        send_item(make_item(KIND_ALLOC, 0, 65535));
        send_item(make_item(KIND_ALLOC, 63, 65535));
        send_item(make_item(KIND_ALLOC, 0, 0));
        send_item(make_item(KIND_ALLOC, 0, 1));
        send_item(make_item(KIND_REPORT, 0, 0));
        send_item(make_item(KIND_SPARE, 63, 65535));
        send_item(make_item(KIND_LOAD, 0, 300));
        send_item(make_item(KIND_LOAD, 1, 200));
        send_item(make_item(KIND_LOAD, 3, 200));
        drain();

        // ties go to the lowest block number
        set_phase(FIT_BEST, 7'd4);
        send_item(make_item(KIND_ALLOC, 0, 150));
        send_item(make_item(KIND_LOAD, 1, 200));
        drain();
        set_phase(FIT_WORST, 7'd4);
        send_item(make_item(KIND_ALLOC, 0, 150));
        send_item(make_item(KIND_ALLOC, 0, 10));
        drain();

        // next fit resumes at the last grant and wraps
        set_phase(FIT_NEXT, 7'd4);
        send_item(make_item(KIND_ALLOC, 0, 0));
        send_item(make_item(KIND_LOAD, 0, 5));
        send_item(make_item(KIND_ALLOC, 0, 0));
        drain();

        for (p = 0; p < 12; p++)
        begin
            set_phase(phase_mode[p], phase_count[p]);
            repeat (PHASE_ITEMS)
                send_item(random_item());
            drain();
        end

        // big leftovers until the internal total clips
        set_phase(FIT_WORST, 7'd64);
        for (r = 0; r < 70; r++)
        begin
            send_item(make_item(KIND_LOAD, r % NUM_BLOCKS, 65535));
            send_item(make_item(KIND_ALLOC, 0, 0));
        end
        send_item(make_item(KIND_REPORT, 0, 0));
        drain();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
